FILE: sv/assert_macros.svh
// Assertion macros used by the sequencer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: sv/nls_pkg.sv
// Types and codes shared by the nested loop sequencer
`timescale 1ns / 1ps

package nls_pkg;

    localparam int PC_W   = 11;
    localparam int VAL_W  = 16;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 32;
    localparam int LEN_W  = 11;
    localparam int DATA_W = 32;
    localparam int ADDR_W_CFG = 3;

    // Register index, taken from paddr bit 2
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_DOOP  = 3'd0,
        KIND_BLOCK = 3'd1,
        KIND_LOOP  = 3'd2,
        KIND_END   = 3'd3,
        KIND_HALT  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        EV_LOADED  = 3'd0,
        EV_LOOPCTL = 3'd1,
        EV_DOOP    = 3'd2,
        EV_BLOCK   = 3'd3,
        EV_HALT    = 3'd4,
        EV_STOPPED = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNMATCHED = 2'd2
    } fault_t;

    typedef enum logic [1:0] {
        RUN_OK        = 2'd0,
        RUN_HALTED    = 2'd1,
        RUN_OVERFLOW  = 2'd2,
        RUN_UNMATCHED = 2'd3
    } run_t;

    typedef struct packed {
        kind_t             kind;
        logic [VAL_W-1:0]  value;
    } instr_t;

    typedef struct packed {
        logic [PC_W-1:0]   start;
        logic [VAL_W-1:0]  left;
    } frame_t;

    typedef struct packed {
        logic [CNT_W-1:0]  clock;
        logic [CNT_W-1:0]  doop_cnt;
        logic [CNT_W-1:0]  doop_sum;
        logic [CNT_W-1:0]  block_cnt;
        logic [CNT_W-1:0]  block_sum;
    } tally_t;

    typedef struct packed {
        event_t            ev;
        run_t              run;
        logic [PC_W-1:0]   pc;
        tally_t            tally;
        logic              frame_we;
        logic              frame_push;
        frame_t            frame_wdata;
        logic              fp_inc;
        logic              fp_dec;
    } step_out_t;

endpackage

FILE: sv/nested_loop_sequencer.sv
// Top level of the nested loop sequencer: memories, state registers, ports
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Nested loop sequencer.
// A word on the command channel is taken at a rising edge with start high and
// busy low. mode 0 loads op_kind/op_value into program slot load_address;
// mode 1 executes the instruction at the program counter and updates the loop
// stack, clock and DOOP/BLOCK tallies.
// The accept edge reads the program memory at the program counter and the top
// loop frame into registers, the next edge commits the new state. busy is high
// for one cycle, and no new word is taken while it is high, so a word is only
// taken once the one before has committed; each step depends on the program
// counter left by the one before, through the synchronous program memory read.
// The result is on the result ports with done high for exactly one cycle, the
// cycle after busy; the receiver cannot stall it.
// The APB port holds program_length at byte address 0; pready is always high.
// Reset clears the program counter, stack pointer, tallies, run status and
// program_length; program memory and loop frames hold anything until written.
module nested_loop_sequencer #(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int STACK_DEPTH   = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [9:0]                          load_address,
    input  logic [nls_pkg::KIND_W-1:0]          op_kind,
    input  logic [nls_pkg::VAL_W-1:0]           op_value,
    // Result channel
    output logic                                done,
    output logic [2:0]                          event_res,
    output logic [1:0]                          fault,
    output logic [nls_pkg::CNT_W-1:0]           stamp,
    output logic [nls_pkg::CNT_W-1:0]           doop_total,
    output logic [nls_pkg::CNT_W-1:0]           doop_duration,
    output logic [nls_pkg::CNT_W-1:0]           block_total,
    output logic [nls_pkg::CNT_W-1:0]           block_duration,
    output logic [nls_pkg::PC_W-1:0]            next_pc,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nls_pkg::ADDR_W_CFG-1:0]      paddr,
    input  logic [nls_pkg::DATA_W-1:0]          pwdata,
    output logic [nls_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import nls_pkg::*;

    localparam int ADDR_W = $clog2(PROGRAM_DEPTH);
    localparam int WIDE_W = (ADDR_W > PC_W) ? ADDR_W : PC_W;
    localparam int FP_W   = $clog2(STACK_DEPTH+1);
    localparam int SP_W   = $clog2(STACK_DEPTH);

    instr_t              prog_mem [PROGRAM_DEPTH];
    frame_t              frame_mem [STACK_DEPTH];

    logic                busy_reg;
    logic                done_reg;
    logic                mode_reg;
    instr_t              instr_reg;
    frame_t              top_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [FP_W-1:0]     fp_reg;
    run_t                run_reg;
    tally_t              tally_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [CNT_W-1:0]    stamp_reg;
    event_t              event_reg;

    logic                accept;
    logic                cfg_write;
    logic                load_hit;
    logic [WIDE_W-1:0]   pc_wide;
    logic [WIDE_W-1:0]   load_wide;
    logic [FP_W-1:0]     fp_less;
    logic [SP_W-1:0]     top_idx;
    logic [SP_W-1:0]     push_idx;
    logic [PC_W-1:0]     act_len;
    step_out_t           so;
    fault_t              fault_code;

    assign accept    = start && !busy_reg;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_PROGRAM_LENGTH);
    assign load_hit  = !mode && (32'(load_address) < PROGRAM_DEPTH);
    assign pc_wide   = WIDE_W'(pc_reg);
    assign load_wide = WIDE_W'(load_address);
    assign fp_less   = fp_reg - FP_W'(1);
    assign top_idx   = fp_less[SP_W-1:0];
    assign push_idx  = fp_reg[SP_W-1:0];
    assign act_len   = (32'(length_reg) > PROGRAM_DEPTH) ? PC_W'(PROGRAM_DEPTH)
                                                          : length_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_write)
        begin
            length_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? DATA_W'(length_reg) : '0;

    // Program memory: load on accept of an in-range mode 0 word, read the word at pc on accept
    always_ff @(posedge clk)
    begin
        if (accept && load_hit)
        begin
            prog_mem[load_wide[ADDR_W-1:0]] <= '{kind: kind_t'(op_kind), value: op_value};
        end
        if (accept)
        begin
            instr_reg <= prog_mem[pc_wide[ADDR_W-1:0]];
        end
    end

    // Loop frame memory: read the top frame on accept, write on commit
    always_ff @(posedge clk)
    begin
        if (busy_reg && so.frame_we)
        begin
            frame_mem[so.frame_push ? push_idx : top_idx] <= so.frame_wdata;
        end
        if (accept)
        begin
            top_reg <= frame_mem[top_idx];
        end
    end

    nls_step #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_step (
        .mode    (mode_reg),
        .run     (run_reg),
        .pc      (pc_reg),
        .act_len (act_len),
        .fp      (fp_reg),
        .instr   (instr_reg),
        .top     (top_reg),
        .tally   (tally_reg),
        .so      (so)
    );

    // Hold the mode of the word in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
        end
    end

    // Handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
        end
    end

    // Commit the step to the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            fp_reg    <= '0;
            run_reg   <= RUN_OK;
            tally_reg <= '0;
        end
        else if (busy_reg)
        begin
            pc_reg    <= so.pc;
            run_reg   <= so.run;
            tally_reg <= so.tally;
            if (so.fp_inc)
            begin
                fp_reg <= fp_reg + FP_W'(1);
            end
            else if (so.fp_dec)
            begin
                fp_reg <= fp_less;
            end
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            stamp_reg <= tally_reg.clock;
            event_reg <= so.ev;
        end
    end

    // Map the run status to the fault code
    always_comb
    begin
        unique case (run_reg)
            RUN_OVERFLOW:  fault_code = FAULT_OVERFLOW;
            RUN_UNMATCHED: fault_code = FAULT_UNMATCHED;
            default:       fault_code = FAULT_NONE;
        endcase
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign event_res      = event_reg;
    assign fault          = fault_code;
    assign stamp          = stamp_reg;
    assign doop_total     = tally_reg.doop_cnt;
    assign doop_duration  = tally_reg.doop_sum;
    assign block_total    = tally_reg.block_cnt;
    assign block_duration = tally_reg.block_sum;
    assign next_pc        = pc_reg;

    `ASSERT_PROP(a_busy_then_done, busy_reg |=> done_reg, "result word missing after busy")
    `ASSERT_NEVER(a_done_while_busy, done_reg && busy_reg, "result shown while still busy")
    `ASSERT_NEVER(a_fp_range, fp_reg > FP_W'(STACK_DEPTH), "loop stack pointer beyond depth")
    `ASSERT_PROP(a_stop_latched, (run_reg != RUN_OK) |=> (run_reg == $past(run_reg)), "halt or fault not held")

endmodule

FILE: sv/nls_step.sv
// Combinational execution of one sequencer word against the current state
`timescale 1ns / 1ps

module nls_step #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                                   mode,
    input  nls_pkg::run_t                          run,
    input  logic [nls_pkg::PC_W-1:0]               pc,
    input  logic [nls_pkg::PC_W-1:0]               act_len,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]       fp,
    input  nls_pkg::instr_t                        instr,
    input  nls_pkg::frame_t                        top,
    input  nls_pkg::tally_t                        tally,
    output nls_pkg::step_out_t                     so
);
    import nls_pkg::*;

    localparam int FP_W = $clog2(STACK_DEPTH+1);

    logic [PC_W-1:0]  pc_inc;
    logic [CNT_W-1:0] val_ext;

    assign pc_inc  = pc + PC_W'(1);
    assign val_ext = CNT_W'(instr.value);

    // Decode the instruction and work out the next state
    always_comb
    begin
        so             = '0;
        so.ev          = EV_LOADED;
        so.run         = run;
        so.pc          = pc;
        so.tally       = tally;
        so.frame_wdata = '{start: pc_inc, left: instr.value};
        if (mode)
        begin
            if (run != RUN_OK || pc >= act_len)
            begin
                so.ev = EV_STOPPED;
            end
            else
            begin
                unique case (instr.kind)
                    KIND_DOOP:
                    begin
                        so.tally.clock    = tally.clock + val_ext;
                        so.tally.doop_cnt = tally.doop_cnt + CNT_W'(1);
                        so.tally.doop_sum = tally.doop_sum + val_ext;
                        so.pc             = pc_inc;
                        so.ev             = EV_DOOP;
                    end
                    KIND_BLOCK:
                    begin
                        so.tally.clock     = tally.clock + val_ext;
                        so.tally.block_cnt = tally.block_cnt + CNT_W'(1);
                        so.tally.block_sum = tally.block_sum + val_ext;
                        so.pc              = pc_inc;
                        so.ev              = EV_BLOCK;
                    end
                    KIND_LOOP:
                    begin
                        if (fp == FP_W'(STACK_DEPTH))
                        begin
                            so.run = RUN_OVERFLOW;
                            so.ev  = EV_STOPPED;
                        end
                        else
                        begin
                            so.frame_we   = 1'b1;
                            so.frame_push = 1'b1;
                            so.fp_inc     = 1'b1;
                            so.pc         = pc_inc;
                            so.ev         = EV_LOOPCTL;
                        end
                    end
                    KIND_END:
                    begin
                        if (fp == '0)
                        begin
                            so.run = RUN_UNMATCHED;
                            so.ev  = EV_STOPPED;
                        end
                        else if (top.left > VAL_W'(1))
                        begin
                            // Jump back and count down the top frame
                            so.frame_we    = 1'b1;
                            so.frame_wdata = '{start: top.start,
                                               left: top.left - VAL_W'(1)};
                            so.pc          = top.start;
                            so.ev          = EV_LOOPCTL;
                        end
                        else
                        begin
                            // Drop the finished frame and fall through
                            so.fp_dec = 1'b1;
                            so.pc     = pc_inc;
                            so.ev     = EV_LOOPCTL;
                        end
                    end
                    default:
                    begin
                        // Halt, and the undefined kinds behave the same
                        so.pc  = act_len;
                        so.run = RUN_HALTED;
                        so.ev  = EV_HALT;
                    end
                endcase
            end
        end
    end

endmodule
